@@ sv/bounded_history_with_cursor_core_defines.svh @@
// Assertion macros shared by the history core checkers.
// Needs clk and rst_n to be visible where a macro is used.
`ifndef BOUNDED_HISTORY_WITH_CURSOR_CORE_DEFINES_SVH
`define BOUNDED_HISTORY_WITH_CURSOR_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define BHC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger
`define BHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bhc_pkg.sv @@
// Shared types, codes and helpers for the bounded history core.
// No dependencies; used by the core, its checker and the testbench.
package bhc_pkg;

    localparam int DEPTH       = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int K_W         = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int CAP_W       = 5;
    localparam int CAP_RESET   = (DEPTH < 16) ? DEPTH : 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Command codes
    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_PEEK  = 3'd1;
    localparam logic [2:0] CMD_MOVE  = 3'd2;
    localparam logic [2:0] CMD_RANGE = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    // Direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_BACK = 2'd1;
    localparam logic [1:0] DIR_FWD  = 2'd2;
    localparam logic [1:0] DIR_BOTH = 2'd3;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;
    localparam logic [1:0] STATUS_DIR   = 2'd3;

    // Register index (byte address / 4)
    localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

    typedef struct packed {
        logic [2:0]           command;
        logic [1:0]           direction;
        logic [7:0]           distance;
        logic [KEY_WIDTH-1:0] item_key;
    } cmd_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 has_item;
        logic [KEY_WIDTH-1:0] entry_key;
        logic                 last;
        logic [3:0]           cursor_out;
        logic [4:0]           length_out;
    } res_t;

    // Slot of an offset from a base slot in the circular store
    function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] base,
                                                    input logic [SLOT_W-1:0] ofs);
        logic [SLOT_W:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= (SLOT_W + 1)'(DEPTH))
            sum = sum - (SLOT_W + 1)'(DEPTH);
        return sum[SLOT_W-1:0];
    endfunction

    // Limit a written capacity to 1..DEPTH
    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (32'(v) > DEPTH)
            r = CNT_W'(DEPTH);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

@@ sv/bhc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/bounded_history_with_cursor_core.sv @@
// Back/forward history of item keys with a cursor, kept in a circular RAM.
// Depends on bhc_pkg and bhc_ram.
//
// A request is taken in the idle state, which also starts the RAM read of the
// one entry it may need; the exec state then applies it and loads the result
// register, waiting while the result side stalls. A range request with entries
// then streams them from the range state, one entry a cycle while the result
// side does not stall, paced by the single RAM read port. New requests are
// refused while one is in progress, but a finished result may still wait in
// the output register while the next request is taken. The key store needs no
// clearing after reset; capacity is written over the APB port only while the
// history is empty and writes at other times are dropped.
module bounded_history_with_cursor_core
    import bhc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cmd_t               cmd,
    // result channel
    output logic               res_valid,
    input  logic               res_stall,
    output res_t               res,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_RANGE} state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] cursor_reg, cursor_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  to_reg, to_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic              cmd_acc;
    logic              res_free;
    logic              res_load;
    logic              cfg_wr;

    // RAM interface
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic                 ram_re;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;
    logic [SLOT_W-1:0]    rd_idx;

    // Add
    logic              add_adv;
    logic              add_hit;
    logic [CNT_W-1:0]  add_cnt1;
    logic              add_evict;
    logic [SLOT_W-1:0] add_oldest;
    logic [CNT_W-1:0]  add_cnt2;
    logic [CNT_W-1:0]  add_cnt3;
    logic [SLOT_W-1:0] add_cursor;

    // Peek and move
    logic [8:0]        cur9;
    logic [8:0]        dist9;
    logic [1:0]        pk_status;
    logic [SLOT_W-1:0] pk_idx;

    // Range
    logic [CNT_W-1:0]  rg_from;
    logic [CNT_W-1:0]  rg_to;
    logic              rg_has_to;
    logic              rg_none;
    logic              rg_last;

    // First entry index of a range around the cursor
    function automatic logic [CNT_W-1:0] range_from(input logic [SLOT_W-1:0] cur,
                                                    input logic [1:0]        dir,
                                                    input logic [7:0]        nb);
        logic [8:0]       c9;
        logic [8:0]       n9;
        logic [CNT_W-1:0] f;
        c9 = 9'(cur);
        n9 = 9'(nb);
        f  = CNT_W'(c9 + 9'd1);
        if (dir[0])
            f = (n9 != 9'd0 && c9 >= n9) ? CNT_W'(c9 - n9) : '0;
        return f;
    endfunction

    bhc_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd_reg.item_key),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign res_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;

    // Read back the capacity register
    assign prdata = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(cap_reg) : '0;

    // Pick the entry a new request needs, read at the accept edge
    always_comb
    begin
        case (cmd.command) inside
            CMD_ADD:
                rd_idx = cursor_reg + SLOT_W'(1);
            CMD_PEEK, CMD_MOVE:
                rd_idx = (cmd.direction == DIR_BACK) ?
                         cursor_reg - SLOT_W'(cmd.distance) :
                         cursor_reg + SLOT_W'(cmd.distance);
            CMD_RANGE:
                rd_idx = SLOT_W'(range_from(cursor_reg, cmd.direction, cmd.distance));
            default:
                rd_idx = '0;
        endcase
    end

    // Add: advance on a matching next entry, else truncate, evict when full and append
    always_comb
    begin
        add_adv    = (CNT_W'(cursor_reg) + CNT_W'(1)) < count_reg;
        add_hit    = add_adv && (ram_rdata == cmd_reg.item_key);
        add_cnt1   = add_adv ? CNT_W'(cursor_reg) + CNT_W'(1) : count_reg;
        add_evict  = add_cnt1 >= cap_reg;
        add_oldest = add_evict ? slot_wrap(oldest_reg, SLOT_W'(1)) : oldest_reg;
        add_cnt2   = add_evict ? add_cnt1 - CNT_W'(1) : add_cnt1;
        add_cnt3   = add_cnt2 + CNT_W'(1);
        add_cursor = (add_cnt3 > CNT_W'(1) && CNT_W'(cursor_reg) < add_cnt3 - CNT_W'(1)) ?
                     cursor_reg + SLOT_W'(1) : cursor_reg;
        ram_waddr  = slot_wrap(add_oldest, SLOT_W'(add_cnt2));
    end

    // Peek and move: check the target against the stored span
    always_comb
    begin
        cur9   = 9'(cursor_reg);
        dist9  = 9'(cmd_reg.distance);
        pk_idx = (cmd_reg.direction == DIR_BACK) ?
                 cursor_reg - SLOT_W'(cmd_reg.distance) :
                 cursor_reg + SLOT_W'(cmd_reg.distance);
        if (count_reg == '0)
            pk_status = STATUS_EMPTY;
        else if (cmd_reg.direction == DIR_BACK)
            pk_status = (cur9 < dist9) ? STATUS_RANGE : STATUS_OK;
        else if (cmd_reg.direction == DIR_FWD)
            pk_status = (cur9 + dist9 >= 9'(count_reg)) ? STATUS_RANGE : STATUS_OK;
        else
            pk_status = STATUS_DIR;
    end

    // Range: bounds of the run around the cursor
    always_comb
    begin
        rg_from   = range_from(cursor_reg, cmd_reg.direction, cmd_reg.distance);
        rg_has_to = (cursor_reg != '0);
        rg_to     = rg_has_to ? CNT_W'(cursor_reg) - CNT_W'(1) : '0;
        if (cmd_reg.direction[1])
        begin
            rg_has_to = 1'b1;
            rg_to     = count_reg - CNT_W'(1);
            if (cmd_reg.distance != 8'd0 && cur9 + dist9 < 9'(rg_to))
                rg_to = CNT_W'(cur9 + dist9);
        end
        rg_none = !rg_has_to || (rg_from > rg_to);
        rg_last = (idx_reg == to_reg) || (k_reg == K_W'(MAX_RESULTS - 1));
    end

    // Sequencer: accept, apply, and stream range entries
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        oldest_next = oldest_reg;
        cap_next    = cap_reg;
        idx_next    = idx_reg;
        to_next     = to_reg;
        k_next      = k_reg;
        res_next    = res_reg;
        res_load    = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = slot_wrap(oldest_reg, rd_idx);

        // Take a capacity write only while the history is empty
        if (cfg_wr && paddr[PADDR_W-1:2] == REG_CAPACITY && count_reg == '0)
            cap_next = clamp_cap(pwdata[CAP_W-1:0]);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    cmd_next   = cmd;
                    ram_re     = 1'b1;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (res_free)
                begin
                    res_load           = 1'b1;
                    res_next.status    = STATUS_OK;
                    res_next.has_item  = 1'b0;
                    res_next.entry_key = '0;
                    res_next.last      = 1'b1;
                    state_next         = ST_IDLE;
                    case (cmd_reg.command) inside
                        CMD_ADD:
                        begin
                            if (add_hit)
                                cursor_next = cursor_reg + SLOT_W'(1);
                            else
                            begin
                                ram_we      = 1'b1;
                                oldest_next = add_oldest;
                                count_next  = add_cnt3;
                                cursor_next = add_cursor;
                            end
                        end
                        CMD_PEEK, CMD_MOVE:
                        begin
                            res_next.status = pk_status;
                            if (pk_status == STATUS_OK)
                            begin
                                res_next.has_item  = 1'b1;
                                res_next.entry_key = ram_rdata;
                                if (cmd_reg.command == CMD_MOVE)
                                    cursor_next = pk_idx;
                            end
                        end
                        CMD_RANGE:
                        begin
                            if (count_reg == '0)
                                res_next.status = STATUS_EMPTY;
                            else if (cmd_reg.direction == DIR_NONE)
                                res_next.status = STATUS_DIR;
                            else if (!rg_none)
                            begin
                                // Hold the result; the first entry is already read
                                res_load   = 1'b0;
                                idx_next   = rg_from;
                                to_next    = rg_to;
                                k_next     = '0;
                                state_next = ST_RANGE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            case (cmd_reg.direction)
                                DIR_BOTH:
                                begin
                                    count_next  = '0;
                                    cursor_next = '0;
                                    oldest_next = '0;
                                end
                                DIR_BACK:
                                begin
                                    if (cursor_reg != '0)
                                    begin
                                        oldest_next = slot_wrap(oldest_reg, cursor_reg);
                                        count_next  = count_reg - CNT_W'(cursor_reg);
                                        cursor_next = '0;
                                    end
                                end
                                DIR_FWD:
                                begin
                                    if (count_reg != '0)
                                        count_next = CNT_W'(cursor_reg) + CNT_W'(1);
                                end
                                default:
                                    res_next.status = STATUS_DIR;
                            endcase
                        end
                        default:
                        begin
                            res_next.status = STATUS_OK;
                        end
                    endcase
                    res_next.cursor_out = 4'(cursor_next);
                    res_next.length_out = 5'(count_next);
                end
            end

            ST_RANGE:
            begin
                if (res_free)
                begin
                    res_load            = 1'b1;
                    res_next.status     = STATUS_OK;
                    res_next.has_item   = 1'b1;
                    res_next.entry_key  = ram_rdata;
                    res_next.last       = rg_last;
                    res_next.cursor_out = 4'(cursor_reg);
                    res_next.length_out = 5'(count_reg);
                    if (rg_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        // Advance to the next entry and fetch it
                        ram_re    = 1'b1;
                        ram_raddr = slot_wrap(oldest_reg, SLOT_W'(idx_reg + CNT_W'(1)));
                        idx_next  = idx_reg + CNT_W'(1);
                        k_next    = k_reg + K_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_valid_next = res_load || (res_valid_reg && res_stall);
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            oldest_reg    <= '0;
            cap_reg       <= CNT_W'(CAP_RESET);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            oldest_reg    <= oldest_next;
            cap_reg       <= cap_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        to_reg  <= to_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

endmodule

@@ sv/bhc_checker.sv @@
// Port-level checks for the bounded history core, bound into the core module.
// Depends on bhc_pkg and the shared assertion macro header.
`include "bounded_history_with_cursor_core_defines.svh"

module bhc_checker
    import bhc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    logic res_held;
    logic req_taken;
    logic res_item;
    logic res_bare;
    logic span_ok;

    assign res_held  = res_valid && res_stall;
    assign req_taken = cmd_valid && !cmd_stall;
    assign res_item  = res_valid && res.has_item;
    assign res_bare  = res_valid && !res.has_item;
    assign span_ok   = (res.length_out == 5'd0 && res.cursor_out == 4'd0) ||
                       (5'(res.cursor_out) < res.length_out && 32'(res.length_out) <= DEPTH);

    // Hold a stalled result
    `BHC_ASSERT_NEXT(a_res_hold, res_held, res_valid && $stable(res), "stalled result changed")

    // Refuse a new request in the cycle after one is taken
    `BHC_ASSERT_NEXT(a_busy_after_req, req_taken, cmd_stall, "request taken back to back")

    // Carry an entry only on a good status, and close every other request at once
    `BHC_ASSERT_NOW(a_item_ok, res_item, res.status == STATUS_OK, "entry with error status")
    `BHC_ASSERT_NOW(a_noitem_last, res_bare, res.last, "itemless result not last")

    // Keep the cursor inside the stored span
    `BHC_ASSERT_NOW(a_cursor_span, res_valid, span_ok, "cursor outside history")

endmodule

bind bounded_history_with_cursor_core bhc_checker u_bhc_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench for bounded_history_with_cursor_core: a directed table, then random
// requests over several capacity settings, scored against fixed rows or a behavioral model.
// Depends on bhc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
    import bhc_pkg::*;

    localparam logic [2:0]         CMD_UNUSED      = 3'd7;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY   = {REG_CAPACITY, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE      = {~REG_CAPACITY, 2'b00};
    localparam int                 PHASES          = 8;
    localparam int                 ITEMS_PER_PHASE = 20;
    localparam int                 HOLD_CYCLES     = 80;
    localparam int                 SETTLE_CYCLES   = 8;
    localparam int                 PRINT_LIMIT     = 50;

    typedef struct {
        cmd_t req;
        bit   fixed;
        res_t want;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    cmd_t               cmd;
    logic               res_valid;
    logic               res_stall;
    res_t               res;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // History model state
    logic [KEY_WIDTH-1:0] hist_key [DEPTH];
    int                   hist_head;
    int                   hist_count;
    int                   hist_cursor;
    int                   hist_cap;

    res_t step_results[$];
    res_t due_results[$];
    res_t oldest_due;
    row_t directed_rows[$];
    int   mismatches = 0;
    bit   calm = 1'b0;
    bit   hold_off = 1'b0;

    bounded_history_with_cursor_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int slot(input int i);
        return (hist_head + i) % DEPTH;
    endfunction

    // Record one result with the current cursor and length
    function automatic void post(input logic [1:0] st, input logic has,
                                 input logic [KEY_WIDTH-1:0] key, input logic fin);
        res_t r;
        r.status     = st;
        r.has_item   = has;
        r.entry_key  = has ? key : '0;
        r.last       = fin;
        r.cursor_out = hist_cursor[3:0];
        r.length_out = hist_count[4:0];
        step_results.push_back(r);
    endfunction

    // Advance the history model by one request and collect its results
    task automatic apply_request(input cmd_t c);
        int idx;
        int from;
        int upto;
        int k;
        bit has_to;
        step_results.delete();
        case (c.command) inside
            CMD_ADD:
            begin
                if (hist_count > 0 && hist_cursor < hist_count - 1)
                begin
                    // same key ahead: just step onto it
                    if (hist_key[slot(hist_cursor + 1)] == c.item_key)
                    begin
                        hist_cursor++;
                        post(STATUS_OK, 1'b0, '0, 1'b1);
                        return;
                    end
                    hist_count = hist_cursor + 1;
                end
                // evict the oldest entry when full
                if (hist_count >= hist_cap)
                begin
                    hist_head = (hist_head + 1) % DEPTH;
                    hist_count--;
                end
                hist_key[slot(hist_count)] = c.item_key;
                hist_count++;
                if (hist_count > 1 && hist_cursor < hist_count - 1)
                    hist_cursor++;
                post(STATUS_OK, 1'b0, '0, 1'b1);
            end
            CMD_PEEK, CMD_MOVE:
            begin
                if (hist_count == 0)
                begin
                    post(STATUS_EMPTY, 1'b0, '0, 1'b1);
                    return;
                end
                if (c.direction == DIR_BACK)
                begin
                    if (hist_cursor < int'(c.distance))
                    begin
                        post(STATUS_RANGE, 1'b0, '0, 1'b1);
                        return;
                    end
                    idx = hist_cursor - int'(c.distance);
                end
                else if (c.direction == DIR_FWD)
                begin
                    if (hist_cursor + int'(c.distance) >= hist_count)
                    begin
                        post(STATUS_RANGE, 1'b0, '0, 1'b1);
                        return;
                    end
                    idx = hist_cursor + int'(c.distance);
                end
                else
                begin
                    post(STATUS_DIR, 1'b0, '0, 1'b1);
                    return;
                end
                if (c.command == CMD_MOVE)
                    hist_cursor = idx;
                post(STATUS_OK, 1'b1, hist_key[slot(idx)], 1'b1);
            end
            CMD_RANGE:
            begin
                if (hist_count == 0)
                begin
                    post(STATUS_EMPTY, 1'b0, '0, 1'b1);
                    return;
                end
                if (c.direction == DIR_NONE)
                begin
                    post(STATUS_DIR, 1'b0, '0, 1'b1);
                    return;
                end
                from   = hist_cursor + 1;
                has_to = hist_cursor > 0;
                upto   = has_to ? hist_cursor - 1 : 0;
                if (c.direction[0])
                    from = (c.distance > 0 && hist_cursor >= int'(c.distance)) ?
                           hist_cursor - int'(c.distance) : 0;
                if (c.direction[1])
                begin
                    has_to = 1'b1;
                    upto   = hist_count - 1;
                    if (c.distance > 0 && hist_cursor + int'(c.distance) < upto)
                        upto = hist_cursor + int'(c.distance);
                end
                if (!has_to || from > upto)
                    post(STATUS_OK, 1'b0, '0, 1'b1);
                else
                    for (k = 0; from + k <= upto && k < MAX_RESULTS; k++)
                        post(STATUS_OK, 1'b1, hist_key[slot(from + k)],
                             (from + k == upto) || (k == MAX_RESULTS - 1));
            end
            CMD_CLEAR:
            begin
                if (c.direction == DIR_BOTH)
                begin
                    hist_count  = 0;
                    hist_cursor = 0;
                    hist_head   = 0;
                end
                else if (c.direction == DIR_BACK)
                begin
                    if (hist_cursor > 0)
                    begin
                        hist_head   = slot(hist_cursor);
                        hist_count -= hist_cursor;
                        hist_cursor = 0;
                    end
                end
                else if (c.direction == DIR_FWD)
                begin
                    if (hist_count > 0)
                        hist_count = hist_cursor + 1;
                end
                post((c.direction == DIR_NONE) ? STATUS_DIR : STATUS_OK, 1'b0, '0, 1'b1);
            end
            default:
                post(STATUS_OK, 1'b0, '0, 1'b1);
        endcase
    endtask

    // Mostly zero, sometimes short, now and then a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(24, 6);
    endfunction

    // Build a random request, biased toward sequences that exercise the history
    function automatic cmd_t gen_request();
        cmd_t c;
        int   r;
        int   pick;
        r           = $urandom_range(99);
        c.direction = 2'($urandom_range(3));
        if ($urandom_range(99) < 75)
            c.distance = 8'($urandom_range(hist_count));
        else
            c.distance = 8'($urandom_range(255));
        c.item_key  = $urandom;
        if (r < 45)
        begin
            c.command = CMD_ADD;
            pick      = $urandom_range(3);
            if (pick == 0 && hist_count > 0 && hist_cursor < hist_count - 1)
                c.item_key = hist_key[slot(hist_cursor + 1)];
            else if (pick == 1)
                c.item_key = 32'hC0DE_0000 | $urandom_range(3);
        end
        else if (r < 65)
        begin
            c.command = ($urandom_range(1)) ? CMD_MOVE : CMD_PEEK;
            if ($urandom_range(99) < 85)
                c.direction = ($urandom_range(1)) ? DIR_FWD : DIR_BACK;
        end
        else if (r < 85)
        begin
            c.command = CMD_RANGE;
            if ($urandom_range(99) < 90)
                c.direction = 2'($urandom_range(3, 1));
        end
        else if (r < 94)
        begin
            c.command = CMD_CLEAR;
            pick      = $urandom_range(99);
            c.direction = (pick < 45) ? DIR_BACK : (pick < 85) ? DIR_FWD :
                          (pick < 95) ? DIR_BOTH : DIR_NONE;
        end
        else
            c.command = 3'($urandom_range(7, 5));
        return c;
    endfunction

    // Offer one request, hold it until taken, then predict its results
    task automatic send(input cmd_t c, input bit fixed, input res_t want);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        apply_request(c);
        if (fixed)
            due_results.push_back(want);
        else
            foreach (step_results[i])
                due_results.push_back(step_results[i]);
    endtask

    // Drop valid and wait until every predicted result is back, then let the core settle
    task automatic drain();
        cmd_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // capacity only changes while the history is empty
        if (addr[PADDR_W-1:2] == REG_CAPACITY && hist_count == 0)
            hist_cap = (data[4:0] == 0) ? 1 : (int'(data[4:0]) > DEPTH) ? DEPTH : int'(data[4:0]);
    endtask

    function automatic row_t mk_row(input logic [2:0] c, input logic [1:0] d,
                                    input logic [7:0] n, input logic [31:0] k, input bit fixed,
                                    input logic [1:0] st, input logic has,
                                    input logic [31:0] ek, input logic [3:0] cur,
                                    input logic [4:0] len);
        row_t r;
        r.req.command       = c;
        r.req.direction     = d;
        r.req.distance      = n;
        r.req.item_key      = k;
        r.fixed             = fixed;
        r.want.status       = st;
        r.want.has_item     = has;
        r.want.entry_key    = ek;
        r.want.last         = 1'b1;
        r.want.cursor_out   = cur;
        r.want.length_out   = len;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Score each result taken from the core against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (due_results.size() == 0)
                flag_mismatch("unexpected result", res.entry_key, '0);
            else
            begin
                oldest_due = due_results.pop_front();
                if (res.status !== oldest_due.status)
                    flag_mismatch("status", res.status, oldest_due.status);
                if (res.has_item !== oldest_due.has_item)
                    flag_mismatch("has_item", res.has_item, oldest_due.has_item);
                if (res.entry_key !== oldest_due.entry_key)
                    flag_mismatch("entry_key", res.entry_key, oldest_due.entry_key);
                if (res.last !== oldest_due.last)
                    flag_mismatch("last", res.last, oldest_due.last);
                if (res.cursor_out !== oldest_due.cursor_out)
                    flag_mismatch("cursor_out", res.cursor_out, oldest_due.cursor_out);
                if (res.length_out !== oldest_due.length_out)
                    flag_mismatch("length_out", res.length_out, oldest_due.length_out);
            end
        end
    end

    // Result side back-pressure: random stalls, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
                hold_off = 1'b0;
            end
            else if (calm)
                res_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                res_stall <= 1'b0;
                if ($urandom_range(99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus
    initial
    begin
        int   cap_plan [PHASES];
        int   cap_value;
        res_t none;
        cap_plan  = '{0, 1, 2, 16, 31, 17, 7, 0};
        none      = '0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        hist_head   = 0;
        hist_count  = 0;
        hist_cursor = 0;
        hist_cap    = CAP_RESET;

        // Empty history, fill, step around, the no-entry ranges, then clear
        directed_rows.push_back(mk_row(CMD_PEEK, DIR_BACK, 8'd0, 32'h0, 1,
                                       STATUS_EMPTY, 0, 32'h0, 4'd0, 5'd0));
        directed_rows.push_back(mk_row(CMD_RANGE, DIR_BOTH, 8'd0, 32'h0, 1,
                                       STATUS_EMPTY, 0, 32'h0, 4'd0, 5'd0));
        directed_rows.push_back(mk_row(CMD_CLEAR, DIR_FWD, 8'd0, 32'h0, 1,
                                       STATUS_OK, 0, 32'h0, 4'd0, 5'd0));
        directed_rows.push_back(mk_row(CMD_CLEAR, DIR_BACK, 8'd0, 32'h0, 1,
                                       STATUS_OK, 0, 32'h0, 4'd0, 5'd0));
        directed_rows.push_back(mk_row(CMD_ADD, DIR_NONE, 8'd0, 32'h0000_0000, 1,
                                       STATUS_OK, 0, 32'h0, 4'd0, 5'd1));
        directed_rows.push_back(mk_row(CMD_ADD, DIR_NONE, 8'd0, 32'hFFFF_FFFF, 1,
                                       STATUS_OK, 0, 32'h0, 4'd1, 5'd2));
        directed_rows.push_back(mk_row(CMD_ADD, DIR_BOTH, 8'hFF, 32'hA5A5_A5A5, 1,
                                       STATUS_OK, 0, 32'h0, 4'd2, 5'd3));
        directed_rows.push_back(mk_row(CMD_ADD, DIR_NONE, 8'd0, 32'h5A5A_5A5A, 1,
                                       STATUS_OK, 0, 32'h0, 4'd3, 5'd4));
        directed_rows.push_back(mk_row(CMD_PEEK, DIR_BACK, 8'd0, 32'h0, 1,
                                       STATUS_OK, 1, 32'h5A5A_5A5A, 4'd3, 5'd4));
        directed_rows.push_back(mk_row(CMD_PEEK, DIR_NONE, 8'd0, 32'h0, 1,
                                       STATUS_DIR, 0, 32'h0, 4'd3, 5'd4));
        directed_rows.push_back(mk_row(CMD_PEEK, DIR_BOTH, 8'd1, 32'h0, 1,
                                       STATUS_DIR, 0, 32'h0, 4'd3, 5'd4));
        directed_rows.push_back(mk_row(CMD_MOVE, DIR_BACK, 8'd255, 32'h0, 1,
                                       STATUS_RANGE, 0, 32'h0, 4'd3, 5'd4));
        directed_rows.push_back(mk_row(CMD_MOVE, DIR_BACK, 8'd2, 32'h0, 1,
                                       STATUS_OK, 1, 32'hFFFF_FFFF, 4'd1, 5'd4));
        // key equal to the next entry: cursor steps, nothing dropped
        directed_rows.push_back(mk_row(CMD_ADD, DIR_NONE, 8'd0, 32'hA5A5_A5A5, 1,
                                       STATUS_OK, 0, 32'h0, 4'd2, 5'd4));
        directed_rows.push_back(mk_row(CMD_RANGE, DIR_NONE, 8'd0, 32'h0, 1,
                                       STATUS_DIR, 0, 32'h0, 4'd2, 5'd4));
        directed_rows.push_back(mk_row(CMD_RANGE, DIR_BOTH, 8'd0, 32'h0, 0,
                                       STATUS_OK, 0, 32'h0, 4'd0, 5'd0));
        directed_rows.push_back(mk_row(CMD_MOVE, DIR_BACK, 8'd2, 32'h0, 1,
                                       STATUS_OK, 1, 32'h0, 4'd0, 5'd4));
        directed_rows.push_back(mk_row(CMD_RANGE, DIR_BACK, 8'd0, 32'h0, 1,
                                       STATUS_OK, 0, 32'h0, 4'd0, 5'd4));
        directed_rows.push_back(mk_row(CMD_MOVE, DIR_FWD, 8'd3, 32'h0, 1,
                                       STATUS_OK, 1, 32'h5A5A_5A5A, 4'd3, 5'd4));
        directed_rows.push_back(mk_row(CMD_RANGE, DIR_FWD, 8'd0, 32'h0, 1,
                                       STATUS_OK, 0, 32'h0, 4'd3, 5'd4));
        directed_rows.push_back(mk_row(CMD_PEEK, DIR_FWD, 8'd1, 32'h0, 1,
                                       STATUS_RANGE, 0, 32'h0, 4'd3, 5'd4));
        directed_rows.push_back(mk_row(CMD_UNUSED, DIR_BOTH, 8'hFF, 32'hFFFF_FFFF, 1,
                                       STATUS_OK, 0, 32'h0, 4'd3, 5'd4));
        directed_rows.push_back(mk_row(CMD_MOVE, DIR_BACK, 8'd2, 32'h0, 1,
                                       STATUS_OK, 1, 32'hFFFF_FFFF, 4'd1, 5'd4));
        // new key in mid-history: entries ahead are dropped
        directed_rows.push_back(mk_row(CMD_ADD, DIR_NONE, 8'd0, 32'h0F0F_0F0F, 0,
                                       STATUS_OK, 0, 32'h0, 4'd0, 5'd0));
        directed_rows.push_back(mk_row(CMD_CLEAR, DIR_BACK, 8'd0, 32'h0, 0,
                                       STATUS_OK, 0, 32'h0, 4'd0, 5'd0));
        directed_rows.push_back(mk_row(CMD_CLEAR, DIR_NONE, 8'd0, 32'h0, 0,
                                       STATUS_OK, 0, 32'h0, 4'd0, 5'd0));
        directed_rows.push_back(mk_row(CMD_CLEAR, DIR_BOTH, 8'd0, 32'h0, 1,
                                       STATUS_OK, 0, 32'h0, 4'd0, 5'd0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            send(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);
        drain();

        // Random phases, each under its own capacity
        for (int p = 0; p < PHASES; p++)
        begin
            // a capacity write while entries remain must be ignored
            if (p % 2 == 1)
                cfg_write(ADDR_CAPACITY, $urandom);
            send('{command: CMD_CLEAR, direction: DIR_BOTH, distance: 8'd0, item_key: '0},
                 1'b0, none);
            drain();
            cap_value = (p == PHASES - 1) ? $urandom_range(31) : cap_plan[p];
            cfg_write(ADDR_CAPACITY, {27'($urandom >> 5), 5'(cap_value)});
            if (p == 3)
                cfg_write(ADDR_SPARE, $urandom);
            calm     = (p == 5);
            hold_off = (p == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send(gen_request(), 1'b0, none);
            drain();
            calm = 1'b0;
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("bounded_history_with_cursor_core regression: pass");
        else
            $display("bounded_history_with_cursor_core regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("bounded_history_with_cursor_core regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/bhc_pkg.sv
sv/bhc_ram.sv
sv/bounded_history_with_cursor_core.sv
sv/bhc_checker.sv
test/tb.sv
